/* hw/rtl/rcls_pkg.sv */
// Shared types and constants for the RC line sensor reader.
package rcls_pkg;

	localparam int OUT_BITS     = 6;
	localparam int NUM_THR_REGS = 6;
	localparam int THR_BITS     = 16;
	localparam int LIMIT_BITS   = 3;
	localparam int CFG_IDX_BITS = 3;

	localparam logic [CFG_IDX_BITS-1:0] REG_DEBOUNCE = 3'd6;

	localparam logic [THR_BITS-1:0]   THR_RESET   = 16'd3000;
	localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 3'd5;

	localparam logic MODE_TICK = 1'b0;
	localparam logic MODE_POLL = 1'b1;

	localparam logic [1:0] PH_DRIVE  = 2'd0;
	localparam logic [1:0] PH_CHARGE = 2'd1;
	localparam logic [1:0] PH_WAIT   = 2'd2;

	typedef struct packed {
		logic                mode;
		logic [OUT_BITS-1:0] pin_levels;
	} rcls_in_t;

	typedef struct packed {
		logic [OUT_BITS-1:0] drive_enable;
		logic [OUT_BITS-1:0] line_mask;
	} rcls_out_t;

	typedef struct packed {
		logic oe;
		logic black;
	} rcls_lane_sts_t;

endpackage

/* hw/rtl/rc_line_sensor_reader.sv */
// Top level of the RC line sensor reader: config registers, lanes, merge.
//
//   port group   dir   handshake            payload
//   in_*         in    in_valid / in_stall   rcls_in_t  {mode, pin_levels}
//   out_*        out   out_valid / out_stall rcls_out_t {drive_enable, line_mask}
//   cfg_*        in    cfg_we               cfg_index, cfg_data
//
// One word in per cycle unless in_stall is high; a result word pushed into an empty buffer
// is visible in the cycle after acceptance. All lanes update in the accept cycle of a tick
// word; one increment and compare per lane sets the path. A two-entry output buffer lets
// input flow while a result waits; in_stall rises only when both entries are held.
// Reset: phases to drive, timers, counts and mask cleared, pins driven, thresholds
// 3000 and debounce limit 5.
module rc_line_sensor_reader #(
	parameter int CHANNELS   = 6,
	parameter int TIMER_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  rcls_pkg::rcls_in_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output rcls_pkg::rcls_out_t                 out_data,
	input  logic                                cfg_we,
	input  logic [rcls_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [rcls_pkg::THR_BITS-1:0]       cfg_data
);
	import rcls_pkg::*;

	logic [THR_BITS-1:0]   thr_q [NUM_THR_REGS];
	logic [LIMIT_BITS-1:0] limit_q;
	logic                  in_acc, advance, full;
	rcls_lane_sts_t        sts [CHANNELS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_THR_REGS; i++)
				thr_q[i] <= THR_RESET;
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			if (cfg_index < CFG_IDX_BITS'(NUM_THR_REGS))
				thr_q[cfg_index] <= cfg_data;
			else if (cfg_index == REG_DEBOUNCE)
				limit_q <= cfg_data[LIMIT_BITS-1:0];
		end
	end

	assign in_stall = full;
	assign in_acc   = in_valid && !in_stall;
	assign advance  = in_acc && (in_data.mode == MODE_TICK);

	for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
		localparam int TI = (g < NUM_THR_REGS) ? g : NUM_THR_REGS - 1;
		logic pin;
		if (g < OUT_BITS) begin : g_pin
			assign pin = in_data.pin_levels[g];
		end else begin : g_nopin
			assign pin = 1'b0;
		end
		rcls_lane #(
			.TIMER_BITS(TIMER_BITS)
		) u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.advance  (advance),
			.pin      (pin),
			.threshold(thr_q[TI]),
			.limit    (limit_q),
			.sts_next (sts[g])
		);
	end

	rcls_merge #(
		.CHANNELS(CHANNELS)
	) u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (in_acc),
		.sts      (sts),
		.full     (full),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

endmodule

/* hw/rtl/rcls_lane.sv */
// One sensor channel: drive/charge/wait sequencer, timer and debounce.
module rcls_lane #(
	parameter int TIMER_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               advance,
	input  logic                               pin,
	input  logic [rcls_pkg::THR_BITS-1:0]      threshold,
	input  logic [rcls_pkg::LIMIT_BITS-1:0]    limit,
	output rcls_pkg::rcls_lane_sts_t           sts_next
);
	import rcls_pkg::*;

	localparam int CW = (TIMER_BITS > THR_BITS) ? TIMER_BITS : THR_BITS;
	localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

	logic [1:0]            phase_q, phase_d;
	logic [TIMER_BITS-1:0] elapsed_q, elapsed_d, el_inc;
	logic [LIMIT_BITS-1:0] cnt_q, cnt_d;
	logic                  black_q, black_d;
	logic                  oe_q, oe_d;
	logic                  timed_out;

	always_comb begin
		el_inc    = (elapsed_q != TMAX) ? elapsed_q + 1'b1 : elapsed_q;
		timed_out = (CW'(el_inc) > CW'(threshold)) || (el_inc == TMAX);
		phase_d   = phase_q;
		elapsed_d = elapsed_q;
		cnt_d     = cnt_q;
		black_d   = black_q;
		oe_d      = oe_q;
		unique case (phase_q)
			PH_CHARGE: begin
				oe_d      = 1'b0;
				elapsed_d = '0;
				phase_d   = PH_WAIT;
			end
			PH_WAIT: begin
				elapsed_d = el_inc;
				if (timed_out || !pin) begin
					if (timed_out) begin
						if (cnt_q < limit)
							cnt_d = cnt_q + 1'b1;
						else
							black_d = 1'b1;
					end else begin
						cnt_d   = '0;
						black_d = 1'b0;
					end
					oe_d    = 1'b1;
					phase_d = PH_DRIVE;
				end
			end
			default: begin
				oe_d    = 1'b1;
				phase_d = PH_CHARGE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_DRIVE;
			elapsed_q <= '0;
			cnt_q     <= '0;
			black_q   <= 1'b0;
			oe_q      <= 1'b1;
		end else if (advance) begin
			phase_q   <= phase_d;
			elapsed_q <= elapsed_d;
			cnt_q     <= cnt_d;
			black_q   <= black_d;
			oe_q      <= oe_d;
		end
	end

	assign sts_next.oe    = advance ? oe_d : oe_q;
	assign sts_next.black = advance ? black_d : black_q;

	a_wait_released: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_WAIT) |-> !oe_q)
		else $error("pin driven during wait phase");

	a_charge_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && phase_q == PH_CHARGE) |=> (phase_q == PH_WAIT && elapsed_q == '0))
		else $error("charge phase did not zero timer");

	a_poll_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> ($stable(phase_q) && $stable(elapsed_q) && $stable(black_q)))
		else $error("lane state moved without a tick");

endmodule

/* hw/rtl/rcls_merge.sv */
// Merge of lane status into result words and a two-entry output buffer.
module rcls_merge #(
	parameter int CHANNELS = 6
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  rcls_pkg::rcls_lane_sts_t  sts [CHANNELS],
	output logic                      full,
	output logic                      out_valid,
	input  logic                      out_stall,
	output rcls_pkg::rcls_out_t       out_data
);
	import rcls_pkg::*;

	rcls_out_t  wdata;
	rcls_out_t  ent_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic       pop;

	always_comb begin
		wdata = '0;
		for (int i = 0; i < OUT_BITS; i++) begin
			if (i < CHANNELS) begin
				wdata.drive_enable[i] = sts[i].oe;
				wdata.line_mask[i]    = sts[i].black;
			end
		end
	end

	assign pop       = out_valid && !out_stall;
	assign out_valid = (cnt_q != 2'd0);
	assign full      = (cnt_q == 2'd2);
	assign out_data  = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_ptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != 2'd3) && !(push && full))
		else $error("output buffer overfilled");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (cnt_q == $past(cnt_q) + 2'd1))
		else $error("push lost");

	a_pass_through: assert property (@(posedge clk) disable iff (!arst_n)
		(push && cnt_q == 2'd0) |=> (out_valid && out_data == $past(wdata)))
		else $error("word not presented after push into empty buffer");

endmodule

/* bench/testbench.sv */
// Self-checking bench for rc_line_sensor_reader: lane mirror, random ticks and polls, config sweeps.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import rcls_pkg::*;

	localparam int LANES        = 6;
	localparam int TIMER_BITS   = 16;
	localparam int LIMIT_CYCLES = 40000;
	localparam logic [TIMER_BITS-1:0] TIMER_TOP = '1;
	localparam logic [CFG_IDX_BITS-1:0] REG_NONE = 3'd7;

	class lane_mirror;
		logic [1:0]            lane_phase [LANES];
		logic [TIMER_BITS-1:0] lane_timer [LANES];
		logic [LIMIT_BITS-1:0] lane_count [LANES];
		logic [THR_BITS-1:0]   lane_thr [NUM_THR_REGS];
		logic [LIMIT_BITS-1:0] db_limit;
		logic [OUT_BITS-1:0]   black;
		logic [OUT_BITS-1:0]   oe;
		rcls_out_t             pending_masks [$];
		int                    errors;

		function new();
			for (int i = 0; i < LANES; i++) begin
				lane_phase[i] = PH_DRIVE;
				lane_timer[i] = '0;
				lane_count[i] = '0;
			end
			for (int i = 0; i < NUM_THR_REGS; i++)
				lane_thr[i] = THR_RESET;
			db_limit = LIMIT_RESET;
			black    = '0;
			oe       = '1;
			errors   = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [THR_BITS-1:0] data);
			if (idx < NUM_THR_REGS)
				lane_thr[idx] = data;
			else if (idx == REG_DEBOUNCE)
				db_limit = data[LIMIT_BITS-1:0];
		endfunction

		function void advance_lane(int ch, logic [OUT_BITS-1:0] pins);
			logic timed_out;
			logic low;
			low = !pins[ch];
			case (lane_phase[ch])
				PH_CHARGE: begin
					oe[ch]         = 1'b0;
					lane_timer[ch] = '0;
					lane_phase[ch] = PH_WAIT;
				end
				PH_WAIT: begin
					if (lane_timer[ch] != TIMER_TOP)
						lane_timer[ch] = lane_timer[ch] + 1'b1;
					timed_out = (lane_timer[ch] > lane_thr[ch]) || (lane_timer[ch] == TIMER_TOP);
					if (timed_out || low) begin
						if (timed_out) begin
							if (lane_count[ch] < db_limit)
								lane_count[ch] = lane_count[ch] + 1'b1;
							else
								black[ch] = 1'b1;
						end else begin
							lane_count[ch] = '0;
							black[ch]      = 1'b0;
						end
						oe[ch]         = 1'b1;
						lane_phase[ch] = PH_DRIVE;
					end
				end
				default: begin
					oe[ch]         = 1'b1;
					lane_phase[ch] = PH_CHARGE;
				end
			endcase
		endfunction

		function void note_word(rcls_in_t w);
			rcls_out_t r;
			if (w.mode == MODE_TICK)
				for (int ch = 0; ch < LANES; ch++)
					advance_lane(ch, w.pin_levels);
			r.drive_enable = oe;
			r.line_mask    = black;
			pending_masks.push_back(r);
		endfunction

		function void check_word(rcls_out_t w);
			rcls_out_t x;
			if (pending_masks.size() == 0) begin
				$error("unexpected result word: drive_enable %h line_mask %h",
					w.drive_enable, w.line_mask);
				errors++;
				return;
			end
			x = pending_masks.pop_front();
			if (w.drive_enable !== x.drive_enable) begin
				$error("drive_enable: expected %h, got %h", x.drive_enable, w.drive_enable);
				errors++;
			end
			if (w.line_mask !== x.line_mask) begin
				$error("line_mask: expected %h, got %h", x.line_mask, w.line_mask);
				errors++;
			end
		endfunction

		function int pending();
			return pending_masks.size();
		endfunction
	endclass

	logic                    clk       = 1'b0;
	logic                    arst_n    = 1'b0;
	logic                    in_valid  = 1'b0;
	logic                    in_stall;
	rcls_in_t                in_data   = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	rcls_out_t               out_data;
	logic                    cfg_we    = 1'b0;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [THR_BITS-1:0]     cfg_data  = '0;

	lane_mirror sb = new();
	int in_idle_pct    = 0;
	int out_stall_pct  = 0;
	int cycles         = 0;

	rc_line_sensor_reader dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < out_stall_pct);
	end

	always @(posedge clk) begin
		if (in_valid && !in_stall)
			sb.note_word(in_data);
		if (out_valid && !out_stall)
			sb.check_word(out_data);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("** rc_line_sensor_reader: FAILED **");
			$finish;
		end
	end

	task automatic send_word(input logic m, input logic [OUT_BITS-1:0] pins);
		rcls_in_t w;
		w.mode       = m;
		w.pin_levels = pins;
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= w;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// hold the sender off until every pending result word is back
	task automatic drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending() != 0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [THR_BITS-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	function automatic logic [THR_BITS-1:0] pick_thr();
		int r;
		r = $urandom_range(99);
		if (r < 8)
			return '0;
		else if (r < 70)
			return THR_BITS'($urandom_range(12, 1));
		else if (r < 85)
			return THR_BITS'($urandom_range(300, 13));
		else if (r < 96)
			return THR_BITS'(1);
		else
			return '1;
	endfunction

	initial begin
		logic [OUT_BITS-1:0] hold;
		logic [OUT_BITS-1:0] pins;
		logic [LIMIT_BITS-1:0] lim;
		logic m;
		int pause_at;
		int r;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(MODE_POLL, 6'h00);
		send_word(MODE_TICK, 6'h3F);
		send_word(MODE_TICK, 6'h3F);
		send_word(MODE_TICK, 6'h00);
		drain();

		write_reg(3'd0, 16'd0);
		write_reg(3'd1, 16'd1);
		write_reg(3'd2, 16'd2);
		write_reg(3'd3, 16'hFFFF);
		write_reg(3'd4, 16'd7);
		write_reg(3'd5, 16'd3);
		write_reg(REG_DEBOUNCE, 16'hFFF8);
		write_reg(REG_NONE, 16'h0001);
		cfg_we <= 1'b0;

		send_word(MODE_POLL, 6'h3F);
		repeat (10) send_word(MODE_TICK, 6'h3F);
		send_word(MODE_TICK, 6'h00);
		send_word(MODE_TICK, 6'h00);
		send_word(MODE_TICK, 6'h00);
		send_word(MODE_TICK, 6'h2A);
		send_word(MODE_TICK, 6'h15);
		send_word(MODE_POLL, 6'h00);
		repeat (4) send_word(MODE_TICK, 6'h3F);
		send_word(MODE_POLL, 6'h3F);
		drain();

		for (int p = 0; p < 6; p++) begin
			case (p / 2)
				0: begin
					in_idle_pct   = 36;
					out_stall_pct = 75;
				end
				1: begin
					in_idle_pct   = 75;
					out_stall_pct = 36;
				end
				default: begin
					in_idle_pct   = 0;
					out_stall_pct = 0;
				end
			endcase
			for (int i = 0; i < NUM_THR_REGS; i++)
				write_reg(CFG_IDX_BITS'(i), pick_thr());
			if (p == 0)
				lim = '0;
			else if (p == 1)
				lim = '1;
			else
				lim = LIMIT_BITS'($urandom_range(7));
			write_reg(REG_DEBOUNCE, {13'($urandom_range(8191)), lim});
			if ($urandom_range(1))
				write_reg(REG_NONE, THR_BITS'($urandom_range(65535)));
			cfg_we <= 1'b0;

			hold     = OUT_BITS'($urandom_range(63) & $urandom_range(63));
			pause_at = $urandom_range(120, 10);
			for (int k = 0; k < 135; k++) begin
				if ($urandom_range(39) == 0)
					hold = OUT_BITS'($urandom_range(63) & $urandom_range(63));
				r = $urandom_range(99);
				if (r < 3)
					pins = '0;
				else if (r < 8)
					pins = OUT_BITS'($urandom_range(63));
				else
					pins = hold | OUT_BITS'($urandom_range(63));
				m = ($urandom_range(99) < 15) ? MODE_POLL : MODE_TICK;
				send_word(m, pins);
				if (k == pause_at)
					drain();
			end
			drain();
		end

		out_stall_pct = 0;
		repeat (5) @(posedge clk);
		if (sb.pending() != 0) begin
			$error("%0d result words never arrived", sb.pending());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("** rc_line_sensor_reader: PASSED **");
		else
			$display("** rc_line_sensor_reader: FAILED **");
		$finish;
	end

endmodule
